[rtl/core/wkp_pkg.sv]
`timescale 1ns / 1ps
// Package for the weighted k-nearest-neighbour predictor: field widths,
// fixed-point formats and default sizes. No dependencies.
package wkp_pkg;

	// defaults for the top-level parameters
	localparam int DEFAULT_MAX_NEIGHBOURS = 16;
	localparam int DEFAULT_DISTANCE_BITS  = 16;

	// fixed field widths
	localparam int DIST_IN_W  = 17;   // signed distance input
	localparam int DIST_MAG_W = 16;   // magnitude part of the distance input
	localparam int RATING_W   = 3;
	localparam int K_W        = 5;
	localparam int PRED_W     = 15;   // Q3.12
	localparam int Q_FRAC     = 12;
	localparam int SEEN_W     = 17;

	// weight = floor(2^16 / (d + 1)), at most 2^16, so 17 quotient bits
	localparam int WEIGHT_W   = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << (WEIGHT_W - 1);

	// divider step counter
	localparam int STEP_W     = 5;

	localparam logic [K_W-1:0] K_RESET = K_W'(4);

endpackage

[rtl/core/weighted_knn_predict.sv]
`timescale 1ns / 1ps
// Top level of the distance-weighted k-nearest-neighbour rating predictor.
// Depends on wkp_pkg for widths and constants.
//
// Each request carries a squared distance, a rating and a last flag. A
// negative distance (the query movie itself) is skipped. Non-negative
// requests are kept in a sorted list of MAX_NEIGHBOURS entries held in
// registers; one shared comparator walks the list from the front to find the
// insertion point (a skipped marker that is not last does not stall the
// input). On the last request the block forms the weights 1/(d+1) one
// neighbour at a time with a shared restoring divider, then divides the
// weighted rating sum by the weight sum on the same divider (15 steps);
// both divisions are skipped when k is 0 or too few neighbours came.
// in_stall stays high while the sequencer works; the result waits in an
// output register, so a new user stream can start before it is taken.
module weighted_knn_predict #(
	parameter int MAX_NEIGHBOURS = wkp_pkg::DEFAULT_MAX_NEIGHBOURS,
	parameter int DISTANCE_BITS  = wkp_pkg::DEFAULT_DISTANCE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [wkp_pkg::DIST_IN_W-1:0] distance,
	input  logic [wkp_pkg::RATING_W-1:0]   rating,
	input  logic                           last_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [wkp_pkg::PRED_W-1:0]     prediction,
	output logic                           too_few,
	input  logic                           cfg_wr_en,
	input  logic [wkp_pkg::K_W-1:0]        cfg_wr_data
);

	localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
	localparam int IW      = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int WSUM_W  = wkp_pkg::WEIGHT_W + $clog2(MAX_NEIGHBOURS);
	localparam int NUM_W   = WSUM_W + wkp_pkg::RATING_W;
	localparam int DVW     = (DISTANCE_BITS + 1 > WSUM_W) ? DISTANCE_BITS + 1 : WSUM_W;
	localparam int QW      = wkp_pkg::WEIGHT_W;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SCAN   = 10'b0000000010,
		S_INSERT = 10'b0000000100,
		S_PREP   = 10'b0000001000,
		S_WLOAD  = 10'b0000010000,
		S_WDIV   = 10'b0000100000,
		S_ACC    = 10'b0001000000,
		S_FSET   = 10'b0010000000,
		S_FDIV   = 10'b0100000000,
		S_EMIT   = 10'b1000000000
	} state_t;

	state_t                          state_q;
	logic [wkp_pkg::SEEN_W-1:0]      seen_q;
	logic [wkp_pkg::K_W-1:0]         nc_q;
	logic                            out_valid_q;
	logic [wkp_pkg::PRED_W-1:0]      out_pred_q;
	logic                            out_few_q;

	// sorted neighbour list
	logic [DISTANCE_BITS-1:0]        best_d_q [MAX_NEIGHBOURS];
	logic [wkp_pkg::RATING_W-1:0]    best_r_q [MAX_NEIGHBOURS];

	// latched request
	logic [DISTANCE_BITS-1:0]        d_q;
	logic [wkp_pkg::RATING_W-1:0]    r_q;
	logic                            last_q;

	logic [CNT_W-1:0]                j_q;
	logic [NUM_W-1:0]                num_q;
	logic [WSUM_W-1:0]               wsum_q;
	logic [wkp_pkg::PRED_W-1:0]      fin_pred_q;
	logic                            fin_few_q;

	// shared divider
	logic [DVW-1:0]                  rem_q;
	logic [DVW-1:0]                  div_q;
	logic [QW-1:0]                   dvd_q;
	logic [QW-1:0]                   quo_q;
	logic [wkp_pkg::STEP_W-1:0]      step_q;

	logic [DISTANCE_BITS-1:0]        dist_sat;
	logic                            in_acc;
	logic                            out_free;
	logic [CNT_W-1:0]                cnt;
	logic [CNT_W-1:0]                k_eff;
	logic [DISTANCE_BITS-1:0]        best_d_rd;
	logic [wkp_pkg::RATING_W-1:0]    best_r_rd;
	logic [DVW:0]                    trial;
	logic                            ge;
	logic [DVW-1:0]                  rem_nx;
	logic                            step_last;

	generate
		if (DISTANCE_BITS >= wkp_pkg::DIST_MAG_W) begin : g_dist_wide
			assign dist_sat = DISTANCE_BITS'(distance[wkp_pkg::DIST_MAG_W-1:0]);
		end else begin : g_dist_narrow
			assign dist_sat = (distance[wkp_pkg::DIST_MAG_W-1:DISTANCE_BITS] != '0) ? '1 :
				distance[DISTANCE_BITS-1:0];
		end
	endgenerate

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign prediction = out_pred_q;
	assign too_few    = out_few_q;

	always_comb begin
		cnt = (seen_q < wkp_pkg::SEEN_W'(MAX_NEIGHBOURS)) ? CNT_W'(seen_q) :
			CNT_W'(MAX_NEIGHBOURS);
		k_eff = (32'(nc_q) > MAX_NEIGHBOURS) ? CNT_W'(MAX_NEIGHBOURS) : CNT_W'(nc_q);
		best_d_rd = best_d_q[j_q[IW-1:0]];
		best_r_rd = best_r_q[j_q[IW-1:0]];
	end

	// one restoring-division step
	always_comb begin
		trial     = {rem_q, dvd_q[QW-1]};
		ge        = (trial >= {1'b0, div_q});
		rem_nx    = ge ? DVW'(trial - {1'b0, div_q}) : trial[DVW-1:0];
		step_last = (step_q == wkp_pkg::STEP_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= '0;
			nc_q        <= wkp_pkg::K_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				nc_q <= cfg_wr_data;
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!distance[wkp_pkg::DIST_IN_W-1]) begin
							state_q <= (cnt == '0) ? S_INSERT : S_SCAN;
						end else if (last_item) begin
							state_q <= S_PREP;
						end
					end
				end
				S_SCAN: begin
					if (best_d_rd > d_q || j_q + CNT_W'(1) == cnt) begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					if (seen_q != '1) begin
						seen_q <= seen_q + wkp_pkg::SEEN_W'(1);
					end
					state_q <= last_q ? S_PREP : S_IDLE;
				end
				S_PREP: begin
					if (k_eff == '0 || seen_q < wkp_pkg::SEEN_W'(k_eff)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WLOAD;
					end
				end
				S_WLOAD: state_q <= S_WDIV;
				S_WDIV: begin
					if (step_last) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					state_q <= (j_q + CNT_W'(1) == k_eff) ? S_FSET : S_WLOAD;
				end
				S_FSET: state_q <= (wsum_q == '0) ? S_EMIT : S_FDIV;
				S_FDIV: begin
					if (step_last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						seen_q      <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				d_q    <= dist_sat;
				r_q    <= rating;
				last_q <= last_item;
				j_q    <= '0;
			end
			S_SCAN: begin
				if (best_d_rd <= d_q) begin
					j_q <= j_q + CNT_W'(1);
				end
			end
			S_INSERT: begin
				// open a slot at j_q; the tail entry drops off when full
				for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
					if (CNT_W'(i) == j_q) begin
						best_d_q[i] <= d_q;
						best_r_q[i] <= r_q;
					end else if (i > 0 && CNT_W'(i) > j_q) begin
						best_d_q[i] <= best_d_q[(i > 0) ? i - 1 : 0];
						best_r_q[i] <= best_r_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
			S_PREP: begin
				j_q        <= '0;
				num_q      <= '0;
				wsum_q     <= '0;
				fin_pred_q <= '0;
				fin_few_q  <= (k_eff != '0) && (seen_q < wkp_pkg::SEEN_W'(k_eff));
			end
			S_WLOAD: begin
				rem_q  <= '0;
				div_q  <= DVW'(best_d_rd) + DVW'(1);
				dvd_q  <= wkp_pkg::WEIGHT_ONE;
				step_q <= wkp_pkg::STEP_W'(QW);
			end
			S_WDIV, S_FDIV: begin
				rem_q  <= rem_nx;
				dvd_q  <= {dvd_q[QW-2:0], 1'b0};
				quo_q  <= {quo_q[QW-2:0], ge};
				step_q <= step_q - wkp_pkg::STEP_W'(1);
				if (state_q == S_FDIV && step_last) begin
					fin_pred_q <= {quo_q[wkp_pkg::PRED_W-2:0], ge};
				end
			end
			S_ACC: begin
				num_q  <= num_q + NUM_W'(quo_q) * NUM_W'(best_r_rd);
				wsum_q <= wsum_q + WSUM_W'(quo_q);
				j_q    <= j_q + CNT_W'(1);
			end
			S_FSET: begin
				// quotient < 2^15, so the top of the dividend starts as remainder
				rem_q  <= DVW'(num_q[NUM_W-1:wkp_pkg::RATING_W]);
				div_q  <= DVW'(wsum_q);
				dvd_q  <= {num_q[wkp_pkg::RATING_W-1:0], {(QW - wkp_pkg::RATING_W){1'b0}}};
				step_q <= wkp_pkg::STEP_W'(wkp_pkg::PRED_W);
			end
			S_EMIT: begin
				if (out_free) begin
					out_pred_q <= fin_pred_q;
					out_few_q  <= fin_few_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/wkp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for weighted_knn_predict, attached with bind.
// Depends on wkp_pkg for field widths.
module wkp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [wkp_pkg::DIST_IN_W-1:0]      distance,
	input logic                               last_item,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [wkp_pkg::PRED_W-1:0]         prediction,
	input logic                               too_few
);

	// a stored neighbour always keeps the sequencer busy after it is taken
	a_store_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !distance[wkp_pkg::DIST_IN_W-1] |=> in_stall)
		else $error("no busy cycle after a stored neighbour");

	// a skipped marker that does not end the stream leaves the input free for the next request
	a_marker_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && distance[wkp_pkg::DIST_IN_W-1] && !last_item |=> !in_stall)
		else $error("marker request held the input");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_few |-> prediction == '0)
		else $error("too_few with nonzero prediction");

	// weighted mean of 3-bit ratings never exceeds 7.0 in Q3.12
	a_pred_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> prediction <= wkp_pkg::PRED_W'(28672))
		else $error("prediction out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prediction) && $stable(too_few))
		else $error("stalled result changed");

endmodule

bind weighted_knn_predict wkp_checker u_wkp_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for weighted_knn_predict (depends on wkp_pkg): directed table, then
// random streams; results checked against the table or an in-file k-nearest model.
module testbench;

	localparam int DIST_IN_W  = wkp_pkg::DIST_IN_W;
	localparam int DIST_MAG_W = wkp_pkg::DIST_MAG_W;
	localparam int RATING_W   = wkp_pkg::RATING_W;
	localparam int PRED_W     = wkp_pkg::PRED_W;
	localparam int K_W        = wkp_pkg::K_W;
	localparam int SEEN_W     = wkp_pkg::SEEN_W;

	localparam int KEEP         = wkp_pkg::DEFAULT_MAX_NEIGHBOURS;
	localparam int ITEM_TARGET  = 1950;
	// covers the worst-case sequencer work after the last request, plus margin
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam logic signed [5:0] NO_CFG = -6'sd1;

	typedef struct packed {
		logic [PRED_W-1:0] pred;
		logic              too_few;
	} verdict_t;

	typedef struct packed {
		logic signed [5:0]           set_k;
		logic signed [DIST_IN_W-1:0] req_dist;
		logic [RATING_W-1:0]         rate;
		logic                        last;
		logic                        typed;
		logic [PRED_W-1:0]           pred;
		logic                        too_few;
	} plan_row_t;

	// k | distance | rating | last | typed | prediction | too_few
	localparam int PLAN_ROWS = 22;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{NO_CFG, 17'sd0, 3'd0, 1'b1, 1'b1, 15'd0, 1'b1},        // one neighbour, k=4
		'{NO_CFG, 17'sd0, 3'd5, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd0, 3'd5, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd0, 3'd5, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd0, 3'd5, 1'b1, 1'b1, 15'd20480, 1'b0},    // four equal neighbours, 5.0
		'{NO_CFG, 17'sd3, 3'd1, 1'b0, 1'b0, 15'd0, 1'b0},        // equal distances
		'{NO_CFG, 17'sd3, 3'd6, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd3, 3'd7, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd3, 3'd2, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd3, 3'd0, 1'b1, 1'b1, 15'd16384, 1'b0},    // earlier four win the tie
		'{NO_CFG, -17'sd1, 3'd7, 1'b1, 1'b1, 15'd0, 1'b1},       // self marker alone
		'{6'sd0, 17'sd65535, 3'd7, 1'b1, 1'b1, 15'd0, 1'b0},     // k = 0
		'{6'sd1, -17'sd65536, 3'd7, 1'b0, 1'b0, 15'd0, 1'b0},    // most negative, skipped
		'{NO_CFG, 17'sd65535, 3'd7, 1'b1, 1'b1, 15'd28672, 1'b0},
		'{6'sd31, 17'sd1, 3'd3, 1'b1, 1'b1, 15'd0, 1'b1},        // k clamps to 16
		'{6'sd2, 17'sd1, 3'd6, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd65535, 3'd0, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, -17'sd1, 3'd0, 1'b1, 1'b0, 15'd0, 1'b0},
		'{6'sd3, 17'sd7, 3'd4, 1'b0, 1'b0, 15'd0, 1'b0},
		'{6'sd1, 17'sd0, 3'd2, 1'b1, 1'b1, 15'd8192, 1'b0},      // k changed mid-stream
		'{NO_CFG, -17'sd1, 3'd5, 1'b0, 1'b0, 15'd0, 1'b0},
		'{NO_CFG, 17'sd65535, 3'd7, 1'b1, 1'b1, 15'd28672, 1'b0}
	};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [DIST_IN_W-1:0] distance = '0;
	logic [RATING_W-1:0]         rating = '0;
	logic                        last_item = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [PRED_W-1:0]           prediction;
	logic                        too_few;
	logic                        cfg_wr_en = 1'b0;
	logic [K_W-1:0]              cfg_wr_data = '0;

	weighted_knn_predict u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.distance    (distance),
		.rating      (rating),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prediction  (prediction),
		.too_few     (too_few),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// nearest-neighbour list model
	logic [DIST_MAG_W-1:0] near_dist [KEEP];
	logic [RATING_W-1:0]   near_rating [KEEP];
	logic [SEEN_W-1:0]     neighbours_seen;
	logic [K_W-1:0]        k_setting;

	verdict_t pending_verdicts [$];
	int       mismatches = 0;
	int       items_sent = 0;
	bit       calm_in = 1'b0;
	bit       calm_out = 1'b0;

	function automatic void clear_neighbours();
		for (int i = 0; i < KEEP; i++) begin
			near_dist[i]   = '1;
			near_rating[i] = '0;
		end
		neighbours_seen = '0;
	endfunction

	function automatic int kept_neighbours();
		return (neighbours_seen < KEEP) ? int'(neighbours_seen) : KEEP;
	endfunction

	// Takes one request; returns 1 with the expected verdict on the last one.
	function automatic bit absorb_neighbour(input logic signed [DIST_IN_W-1:0] d,
			input logic [RATING_W-1:0] r, input logic last, output verdict_t v);
		int          cnt;
		int          pos;
		int          j;
		int          k_eff;
		logic [63:0] w;
		logic [63:0] num;
		logic [63:0] wsum;
		v = '0;
		if (!d[DIST_IN_W-1]) begin
			cnt = kept_neighbours();
			pos = 0;
			while (pos < cnt && near_dist[pos] <= d[DIST_MAG_W-1:0])
				pos++;
			if (pos < KEEP) begin
				j = (cnt < KEEP) ? cnt : KEEP - 1;
				while (j > pos) begin
					near_dist[j]   = near_dist[j-1];
					near_rating[j] = near_rating[j-1];
					j--;
				end
				near_dist[pos]   = d[DIST_MAG_W-1:0];
				near_rating[pos] = r;
			end
			if (neighbours_seen != '1)
				neighbours_seen++;
		end
		if (!last)
			return 1'b0;
		k_eff = (k_setting > KEEP) ? KEEP : int'(k_setting);
		cnt   = kept_neighbours();
		num   = '0;
		wsum  = '0;
		if (k_eff != 0) begin
			if (neighbours_seen < k_eff) begin
				v.too_few = 1'b1;
			end else begin
				for (j = 0; j < k_eff && j < cnt; j++) begin
					w = 64'd65536 / (64'(near_dist[j]) + 64'd1);
					num  += w * 64'(near_rating[j]);
					wsum += w;
				end
				if (wsum != 0)
					v.pred = PRED_W'((num * 64'd4096) / wsum);
			end
		end
		clear_neighbours();
		return 1'b1;
	endfunction

	task automatic offer(input logic signed [DIST_IN_W-1:0] d, input logic [RATING_W-1:0] r,
			input logic last, input bit typed, input verdict_t typed_v);
		int       gap;
		verdict_t v;
		gap = calm_in ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		distance  <= d;
		rating    <= r;
		last_item <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
		if (absorb_neighbour(d, r, last, v))
			pending_verdicts.push_back(typed ? typed_v : v);
	endtask

	// k may only change while nothing is in flight
	task automatic set_neighbour_count(input logic [K_W-1:0] k);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= k;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		k_setting  = k;
	endtask

	function automatic logic signed [DIST_IN_W-1:0] draw_distance();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 6)
			return ($urandom_range(0, 1) != 0) ? -17'sd1 : {1'b1, 16'($urandom)};
		if (sel < 40)
			return 17'($urandom_range(0, 15));
		if (sel < 55)
			return ($urandom_range(0, 1) != 0) ? 17'sd65535 : 17'sd0;
		return {1'b0, 16'($urandom)};
	endfunction

	function automatic logic [RATING_W-1:0] draw_rating();
		return ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
	endfunction

	function automatic logic [K_W-1:0] draw_k();
		case ($urandom_range(0, 7))
			0: return 5'd0;
			1: return 5'd1;
			2: return 5'd16;
			3: return 5'd17;
			4: return 5'd31;
			5: return 5'd2;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	function automatic int draw_stream_len();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return $urandom_range(1, 20);
		if (sel < 19)
			return $urandom_range(17, 40);
		return $urandom_range(1, 3);
	endfunction

	// result side
	initial begin
		int       hold;
		verdict_t want;
		wait (arst_n === 1'b1);
		forever begin
			hold = calm_out ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pred=%0d too_few=%0b", prediction, too_few);
			end else begin
				want = pending_verdicts.pop_front();
				if (prediction !== want.pred || too_few !== want.too_few) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pred=%0d too_few=%0b, got pred=%0d too_few=%0b",
							want.pred, want.too_few, prediction, too_few);
				end
			end
		end
	end

	// request side
	initial begin
		int streams;
		int len;
		clear_neighbours();
		k_setting = wkp_pkg::K_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].set_k >= 0)
				set_neighbour_count(K_W'(PLAN[i].set_k));
			offer(PLAN[i].req_dist, PLAN[i].rate, PLAN[i].last, PLAN[i].typed,
				'{pred: PLAN[i].pred, too_few: PLAN[i].too_few});
		end

		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			set_neighbour_count(draw_k());
			calm_in  = ($urandom_range(0, 3) == 0);
			calm_out = ($urandom_range(0, 3) == 0);
			streams  = $urandom_range(1, 4);
			repeat (streams) begin
				len = draw_stream_len();
				for (int i = 0; i < len; i++)
					offer(draw_distance(), draw_rating(), i == len - 1, 1'b0, '0);
			end
			// sometimes leave a stream open so k changes under it
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 6))
					offer(draw_distance(), draw_rating(), 1'b0, 1'b0, '0);
		end
		offer(draw_distance(), draw_rating(), 1'b1, 1'b0, '0);

		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
